FILE: src/matrix4_vector_transform_unit_macros.svh
// assertion macros for the matrix4 vector transform unit
// used by the top level only, expects signals named clock and reset in scope
`ifndef MATRIX4_VECTOR_TRANSFORM_UNIT_MACROS_SVH
`define MATRIX4_VECTOR_TRANSFORM_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define M4VT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define M4VT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/m4vt_pkg.sv
// shared types and constants of the matrix4 vector transform unit
// no dependencies; imported by every module of the block but m4vt_ram
package m4vt_pkg;

   // field widths and matrix geometry
   localparam int DATA_W            = 32;
   localparam int INDEX_W           = 4;
   localparam int ACTION_W          = 2;
   localparam int MAT_DIM           = 4;
   localparam int OUT_ROWS          = 3;
   localparam int WORD_ENTRIES      = OUT_ROWS * MAT_DIM;
   localparam int PROD_W            = 2 * DATA_W;
   localparam int SUM_W             = PROD_W + 2;
   localparam int FRAC_BITS_DEFAULT = 16;

   // fourth row feeds a dropped component and is never stored
   localparam logic [INDEX_W-3:0] DROPPED_ROW = 2'd3;

   // request action codes
   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD   = 2'd0,
      ACT_POINT  = 2'd1,
      ACT_VECTOR = 2'd2
   } action_type;

   // rows 0 to 2 of the matrix, entry e at row e/4, column e%4
   typedef logic [WORD_ENTRIES-1:0][DATA_W-1:0] matrix_type;
   typedef logic [MAT_DIM-1:0][DATA_W-1:0]      vector_type;

   // entry write from the request side
   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] index;
      logic [DATA_W-1:0]  value;
   } load_type;

   // matrix store status
   typedef struct packed {
      logic word_valid;
      logic fwd_valid;
   } store_status_type;

endpackage

FILE: src/m4vt_ram.sv
// generic single-port synchronous ram with registered read data
// no dependencies
module m4vt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and read-before-write read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/m4vt_store.sv
// matrix store: ram word holding rows 0 to 2, read-modify-write of one entry per load
// depends on m4vt_pkg and m4vt_ram
module m4vt_store import m4vt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  load_type         load,
   output matrix_type       matrix,
   output store_status_type status
);

   matrix_type ram_rd_data;
   matrix_type wr_word_in;
   matrix_type wr_word_ff;
   logic       wr_en;
   logic       fwd_valid_in;
   logic       fwd_valid_ff;
   logic       word_valid_in;
   logic       word_valid_ff;

   // storage, always read at its single word
   m4vt_ram #(
      .WIDTH ($bits(matrix_type)),
      .DEPTH (1)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (1'b0),
      .wr_data (wr_word_in),
      .rd_data (ram_rd_data)
   );

   // current matrix: last write forwarded over the ram, zero until first write
   always_comb begin
      if (!word_valid_ff) begin
         matrix = '0;
      end else if (fwd_valid_ff) begin
         matrix = wr_word_ff;
      end else begin
         matrix = ram_rd_data;
      end
   end

   // merge the loaded entry into the current word
   always_comb begin
      wr_en         = load.en && (load.index[INDEX_W-1:2] != DROPPED_ROW);
      wr_word_in    = matrix;
      if (wr_en) begin
         wr_word_in[load.index] = load.value;
      end
      fwd_valid_in  = wr_en;
      word_valid_in = word_valid_ff || wr_en;
   end

   // forwarding and valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff  <= 1'b0;
         word_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff  <= fwd_valid_in;
         word_valid_ff <= word_valid_in;
      end
   end

   // forwarded word copy
   always_ff @(posedge clock) begin
      if (wr_en) begin
         wr_word_ff <= wr_word_in;
      end
   end

   assign status.word_valid = word_valid_ff;
   assign status.fwd_valid  = fwd_valid_ff;

endmodule

FILE: src/m4vt_dot.sv
// transform pipeline: products, pair sums, row sums, shift and saturate
// depends on m4vt_pkg
module m4vt_dot import m4vt_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  vector_type        vec,
   input  matrix_type        matrix,
   output logic              in_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_out_x,
   output logic [DATA_W-1:0] rsp_out_y,
   output logic [DATA_W-1:0] rsp_out_z,
   output logic              rsp_saturated
);

   logic signed [PROD_W-1:0] prod_in  [OUT_ROWS][MAT_DIM];
   logic signed [PROD_W-1:0] prod_ff  [OUT_ROWS][MAT_DIM];
   logic signed [SUM_W-1:0]  pair_in  [OUT_ROWS][2];
   logic signed [SUM_W-1:0]  pair_ff  [OUT_ROWS][2];
   logic signed [SUM_W-1:0]  sum_in   [OUT_ROWS];
   logic signed [SUM_W-1:0]  sum_ff   [OUT_ROWS];
   logic [DATA_W-1:0]        res_in   [OUT_ROWS];
   logic [DATA_W-1:0]        res_ff   [OUT_ROWS];
   logic                     sat_in;
   logic                     sat_ff;
   logic                     v1_ff, v2_ff, v3_ff, out_valid_ff;
   logic                     en1, en2, en3, en_out;

   // stage enables: a stage loads when empty or when its contents move on
   always_comb begin
      en_out   = !out_valid_ff || !rsp_stall;
      en3      = !v3_ff || en_out;
      en2      = !v2_ff || en3;
      en1      = !v1_ff || en2;
      in_ready = en1;
   end

   // stage 1: twelve exact products
   always_comb begin
      for (int r = 0; r < OUT_ROWS; r++) begin
         for (int c = 0; c < MAT_DIM; c++) begin
            prod_in[r][c] = $signed(matrix[r*MAT_DIM+c]) * $signed(vec[c]);
         end
      end
   end

   // stage 2: pair sums
   always_comb begin
      for (int r = 0; r < OUT_ROWS; r++) begin
         for (int h = 0; h < 2; h++) begin
            pair_in[r][h] = SUM_W'(prod_ff[r][2*h]) + SUM_W'(prod_ff[r][2*h+1]);
         end
      end
   end

   // stage 3: row sums
   always_comb begin
      for (int r = 0; r < OUT_ROWS; r++) begin
         sum_in[r] = pair_ff[r][0] + pair_ff[r][1];
      end
   end

   // output stage: floor shift and clip to 32 bits
   always_comb begin
      logic signed [SUM_W-1:0]    shifted;
      logic [SUM_W-DATA_W:0]      upper;
      sat_in = 1'b0;
      for (int r = 0; r < OUT_ROWS; r++) begin
         shifted = sum_ff[r] >>> FRAC_BITS;
         upper   = shifted[SUM_W-1:DATA_W-1];
         if ((&upper) || !(|upper)) begin
            res_in[r] = shifted[DATA_W-1:0];
         end else begin
            sat_in    = 1'b1;
            res_in[r] = shifted[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}};
         end
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= start;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en_out) begin
            out_valid_ff <= v3_ff;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en1 && start) begin
         prod_ff <= prod_in;
      end
      if (en2 && v1_ff) begin
         pair_ff <= pair_in;
      end
      if (en3 && v2_ff) begin
         sum_ff <= sum_in;
      end
      if (en_out && v3_ff) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_x     = res_ff[0];
   assign rsp_out_y     = res_ff[1];
   assign rsp_out_z     = res_ff[2];
   assign rsp_saturated = sat_ff;

endmodule

FILE: src/matrix4_vector_transform_unit.sv
// Matrix4 vector transform unit: 4x4 signed Q16.16 matrix times vector.
// Request channel (req_valid / req_stall): action 0 writes one matrix entry
// (req_entry_index = row*4 + column, req_entry_value); action 1 transforms
// (x, y, z, 1.0); action 2 transforms (x, y, z, req_in_w); action 3 is dropped.
// Response channel (rsp_valid / rsp_stall): one response per transform with
// rows 0..2 dotted with the vector, floor-shifted and clipped to 32 bits;
// rsp_saturated flags any clipped component. Row 3 writes are accepted and
// discarded since that component is never returned.
// Throughput: one request per cycle while req_stall is low, loads and
// transforms freely mixed; a transform sees every load accepted before it.
// An accepted transform passes the product, pair sum, row sum and output
// registers in that order before it shows on rsp_valid.
// While rsp_stall is high the pipeline still fills its empty stages;
// req_stall rises only when all four stages hold a result.
// Reset clears the matrix to zero at once (a valid flag on the stored word)
// and empties the pipeline; no clearing pass is needed.
// depends on m4vt_pkg, m4vt_store, m4vt_dot and the macros header
`include "matrix4_vector_transform_unit_macros.svh"

module matrix4_vector_transform_unit import m4vt_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [INDEX_W-1:0]  req_entry_index,
   input  logic [DATA_W-1:0]   req_entry_value,
   input  logic [DATA_W-1:0]   req_in_x,
   input  logic [DATA_W-1:0]   req_in_y,
   input  logic [DATA_W-1:0]   req_in_z,
   input  logic [DATA_W-1:0]   req_in_w,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DATA_W-1:0]   rsp_out_x,
   output logic [DATA_W-1:0]   rsp_out_y,
   output logic [DATA_W-1:0]   rsp_out_z,
   output logic                rsp_saturated
);

   // clipped component values
   localparam logic [DATA_W-1:0] CLIP_HIGH = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] CLIP_LOW  = {1'b1, {(DATA_W-1){1'b0}}};

   logic             accept;
   logic             in_ready;
   logic             start;
   load_type         load;
   vector_type       vec;
   matrix_type       matrix;
   store_status_type store_status;
   logic             load_kept;
   logic             rsp_clipped;

   // request decode
   always_comb begin
      accept     = req_valid && !req_stall;
      start      = 1'b0;
      load.en    = 1'b0;
      load.index = req_entry_index;
      load.value = req_entry_value;
      vec[0]     = req_in_x;
      vec[1]     = req_in_y;
      vec[2]     = req_in_z;
      vec[3]     = req_in_w;
      unique case (req_action)
         ACT_LOAD: begin
            load.en = accept;
         end
         ACT_POINT: begin
            start  = accept;
            vec[3] = DATA_W'(1) << FRAC_BITS;
         end
         ACT_VECTOR: begin
            start = accept;
         end
         default: begin
            start = 1'b0;
         end
      endcase
   end

   assign req_stall = !in_ready;

   // matrix storage
   m4vt_store u_store (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .matrix (matrix),
      .status (store_status)
   );

   // transform pipeline
   m4vt_dot #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dot (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .vec           (vec),
      .matrix        (matrix),
      .in_ready      (in_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_saturated (rsp_saturated)
   );

   // check terms
   assign load_kept   = accept && (req_action == ACT_LOAD)
                        && (req_entry_index[INDEX_W-1:2] != DROPPED_ROW);
   assign rsp_clipped = (rsp_out_x == CLIP_HIGH) || (rsp_out_x == CLIP_LOW)
                        || (rsp_out_y == CLIP_HIGH) || (rsp_out_y == CLIP_LOW)
                        || (rsp_out_z == CLIP_HIGH) || (rsp_out_z == CLIP_LOW);

   // checks
   `M4VT_ASSERT_IMPL(a_stall_only_when_full, req_stall, rsp_valid && rsp_stall, "request stalled")
   `M4VT_ASSERT_NEXT(a_load_forwarded, load_kept, store_status.fwd_valid, "load not forwarded")
   `M4VT_ASSERT_IMPL(a_sat_has_clipped_value, rsp_valid && rsp_saturated, rsp_clipped, "bad sat")

endmodule
